>>> hw/rtl/crc_pkg.sv
package crc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // limb width of the b operand in the limb-serial multipliers
  localparam int LIMB = 16;

  // narrower limb for the wide discriminant products
  localparam int LIMB_WIDE = 8;

  localparam int CW   = 32;
  localparam int RW   = 31;
  localparam int IDXW = 3;

  typedef enum logic [IDXW-1:0] {
    REG_CENTRE_X    = 3'd0,
    REG_CENTRE_Y    = 3'd1,
    REG_CENTRE_Z    = 3'd2,
    REG_CONE_RADIUS = 3'd3,
    REG_CONE_HEIGHT = 3'd4
  } reg_idx_t;

  localparam logic [RW-1:0] RADIUS_RST = 31'd65536;
  localparam logic [RW-1:0] HEIGHT_RST = 31'd65536;

endpackage

>>> hw/rtl/crc_delay.sv
module crc_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [D];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < D; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[D-1];

endmodule

>>> hw/rtl/crc_mul.sv
module crc_mul #(
  parameter int WA = 34,
  parameter int WB = 34,
  parameter int LB = crc_pkg::LIMB
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NS  = (WB + LB - 1) / LB;
  localparam int WBE = NS * LB;
  localparam int WP  = WA + WB;
  localparam int WPK = WA + LB + 1;

  logic signed [WA-1:0]  a_q   [NS];
  logic signed [WBE-1:0] b_q   [NS];
  logic signed [WP-1:0]  acc_q [NS];

  // one limb of b per stage, accumulated at its weight
  for (genvar k = 0; k < NS; k++) begin : g_st
    logic signed [WA-1:0]  a_in;
    logic signed [WBE-1:0] b_in;
    logic signed [WP-1:0]  acc_in;
    logic [LB-1:0]         limb;
    logic signed [WPK-1:0] ae;
    logic signed [WPK-1:0] le;
    logic signed [WPK-1:0] pk;

    if (k == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = WBE'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[k-1];
      assign b_in   = b_q[k-1];
      assign acc_in = acc_q[k-1];
    end

    assign limb = b_in[k*LB +: LB];
    assign ae   = WPK'(a_in);

    // top limb carries the sign, lower limbs are unsigned
    if (k == NS - 1) begin : g_top
      assign le = WPK'($signed(limb));
    end else begin : g_low
      assign le = WPK'($signed({1'b0, limb}));
    end

    assign pk = ae * le;

    always_ff @(posedge clk) begin
      if (en) begin
        a_q[k]   <= a_in;
        b_q[k]   <= b_in;
        acc_q[k] <= acc_in + (WP'(pk) <<< (k * LB));
      end
    end
  end

  assign p = acc_q[NS-1];

endmodule

>>> hw/rtl/cone_ray_intersection.sv
// Throughput: one ray per clock while the output is not stalled; the limb-serial
// multipliers (one limb per stage), the square root (one root bit per stage) and
// the divider (one quotient bit per stage) set the depth.
// A stall on the output freezes every stage; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and loads the cone
// registers with centre 0, radius 1.0 and height 1.0.
module cone_ray_intersection #(
  parameter int FRAC_BITS = crc_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each, from bit 0)
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit [0], distance [32:1], zero fill [39:33]
  output logic [39:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [crc_pkg::IDXW-1:0] cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int F     = FRAC_BITS;
  localparam int CW    = crc_pkg::CW;
  localparam int RW    = crc_pkg::RW;
  localparam int LB    = crc_pkg::LIMB;
  localparam int LB3   = crc_pkg::LIMB_WIDE;
  localparam int W1    = 34;
  localparam int WP1   = 2 * W1;
  localparam int WS1   = WP1 + 1;
  localparam int WP2   = 2 * WS1;
  localparam int WABC  = WP2 + 2;
  localparam int WP3   = 2 * WABC;
  localparam int WD    = 272;
  localparam int WR    = WD / 2;
  localparam int WSQ   = WR + 3;
  localparam int W1K   = WD + 10;
  localparam int WTHR  = WP2 + 4 * F;
  localparam int WCMP  = ((W1K > WTHR) ? W1K : WTHR) + 1;
  localparam int QB    = 33;
  localparam int WNS   = WABC + 2;
  localparam int WN    = WNS + F;
  localparam int WDEN  = WABC + 1;
  localparam int WV    = (WN > WDEN + QB) ? WN : WDEN + QB;
  localparam int L1    = (W1 + LB - 1) / LB;
  localparam int L2    = (WS1 + LB - 1) / LB;
  localparam int L3    = (WABC + LB3 - 1) / LB3;
  localparam int LSQ   = WR;
  localparam int LDV   = QB;
  localparam int P1    = L1 + 1;
  localparam int P2    = P1 + L2 + 1;
  localparam int P3    = P2 + L3 + 1;
  localparam int P4    = P3 + 1;
  localparam int P5    = P4 + 1;
  localparam int PSQ   = P5 + LSQ;
  localparam int P6    = PSQ + 1;
  localparam int P7    = P6 + 1;
  localparam int PDV   = P7 + LDV;
  localparam int P8    = PDV + 1;
  localparam int P9    = P8 + 1;
  localparam int P10   = P9 + 1;
  localparam int LAT   = P10 + 1;
  localparam logic [CW-1:0] MISS     = CW'(-(64'sd1 <<< F));
  localparam logic [QB:0]   QMAX_NEG = (QB+1)'(64'h8000_0000);
  localparam logic [QB:0]   QMAX_POS = (QB+1)'(64'h7FFF_FFFF);

  // ---------------------------------------------------------------- config
  logic signed [CW-1:0] centre_x, centre_y, centre_z;
  logic [RW-1:0]        cone_radius, cone_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x    <= '0;
      centre_y    <= '0;
      centre_z    <= '0;
      cone_radius <= crc_pkg::RADIUS_RST;
      cone_height <= crc_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (crc_pkg::reg_idx_t'(cfg_index))
        crc_pkg::REG_CENTRE_X:    centre_x    <= $signed(cfg_data);
        crc_pkg::REG_CENTRE_Y:    centre_y    <= $signed(cfg_data);
        crc_pkg::REG_CENTRE_Z:    centre_z    <= $signed(cfg_data);
        crc_pkg::REG_CONE_RADIUS: cone_radius <= cfg_data[RW-1:0];
        crc_pkg::REG_CONE_HEIGHT: cone_height <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  logic           adv;
  logic [LAT-1:0] v;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = v[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[LAT-2:0], s_tvalid};
    end
  end

  // ---------------------------------------------------------------- stage 0
  logic signed [CW-1:0] in_ox, in_oy, in_oz, in_dx, in_dy, in_dz;
  logic signed [W1-1:0] an0, bn0, dn0, hh0, rr0;
  logic signed [CW-1:0] dx0, dy0, dz0, oy0;

  assign in_ox = $signed(s_tdata[31:0]);
  assign in_oy = $signed(s_tdata[63:32]);
  assign in_oz = $signed(s_tdata[95:64]);
  assign in_dx = $signed(s_tdata[127:96]);
  assign in_dy = $signed(s_tdata[159:128]);
  assign in_dz = $signed(s_tdata[191:160]);

  always_ff @(posedge clk) begin
    if (adv) begin
      an0 <= W1'(in_ox) - W1'(centre_x);
      bn0 <= W1'(in_oz) - W1'(centre_z);
      dn0 <= $signed({3'b000, cone_height}) - W1'(in_oy) + W1'(centre_y);
      hh0 <= $signed({3'b000, cone_height});
      rr0 <= $signed({3'b000, cone_radius});
      dx0 <= in_dx;
      dy0 <= in_dy;
      dz0 <= in_dz;
      oy0 <= in_oy;
    end
  end

  // ---------------------------------------------------------------- round 1
  // dx^2, dz^2, dy^2, an*dx, bn*dz, dn*dy, an^2, bn^2, dn^2, H^2, R^2
  logic signed [W1-1:0]  m1a [11];
  logic signed [W1-1:0]  m1b [11];
  logic signed [WP1-1:0] m1p [11];

  assign m1a[0]  = W1'(dx0);  assign m1b[0]  = W1'(dx0);
  assign m1a[1]  = W1'(dz0);  assign m1b[1]  = W1'(dz0);
  assign m1a[2]  = W1'(dy0);  assign m1b[2]  = W1'(dy0);
  assign m1a[3]  = an0;       assign m1b[3]  = W1'(dx0);
  assign m1a[4]  = bn0;       assign m1b[4]  = W1'(dz0);
  assign m1a[5]  = dn0;       assign m1b[5]  = W1'(dy0);
  assign m1a[6]  = an0;       assign m1b[6]  = an0;
  assign m1a[7]  = bn0;       assign m1b[7]  = bn0;
  assign m1a[8]  = dn0;       assign m1b[8]  = dn0;
  assign m1a[9]  = hh0;       assign m1b[9]  = hh0;
  assign m1a[10] = rr0;       assign m1b[10] = rr0;

  for (genvar i = 0; i < 11; i++) begin : g_m1
    crc_mul #(.WA(W1), .WB(W1), .LB(LB)) u_mul (
      .clk (clk),
      .en  (adv),
      .a   (m1a[i]),
      .b   (m1b[i]),
      .p   (m1p[i])
    );
  end

  logic signed [WS1-1:0] sdd1, sad1, saa1, dy21, dndy1, dn21, h21, r21;

  always_ff @(posedge clk) begin
    if (adv) begin
      sdd1  <= WS1'(m1p[0]) + WS1'(m1p[1]);
      sad1  <= WS1'(m1p[3]) + WS1'(m1p[4]);
      saa1  <= WS1'(m1p[6]) + WS1'(m1p[7]);
      dy21  <= WS1'(m1p[2]);
      dndy1 <= WS1'(m1p[5]);
      dn21  <= WS1'(m1p[8]);
      h21   <= WS1'(m1p[9]);
      r21   <= WS1'(m1p[10]);
    end
  end

  // ---------------------------------------------------------------- round 2
  logic signed [WS1-1:0] m2a [7];
  logic signed [WS1-1:0] m2b [7];
  logic signed [WP2-1:0] m2p [7];

  assign m2a[0] = h21; assign m2b[0] = sdd1;
  assign m2a[1] = r21; assign m2b[1] = dy21;
  assign m2a[2] = h21; assign m2b[2] = sad1;
  assign m2a[3] = r21; assign m2b[3] = dndy1;
  assign m2a[4] = h21; assign m2b[4] = saa1;
  assign m2a[5] = r21; assign m2b[5] = dn21;
  assign m2a[6] = h21; assign m2b[6] = h21;

  for (genvar i = 0; i < 7; i++) begin : g_m2
    crc_mul #(.WA(WS1), .WB(WS1), .LB(LB)) u_mul (
      .clk (clk),
      .en  (adv),
      .a   (m2a[i]),
      .b   (m2b[i]),
      .p   (m2p[i])
    );
  end

  logic signed [WABC-1:0] qa2, qb2, qc2;
  logic signed [WP2-1:0]  h42;

  always_ff @(posedge clk) begin
    if (adv) begin
      qa2 <= WABC'(m2p[0]) - WABC'(m2p[1]);
      qb2 <= (WABC'(m2p[2]) + WABC'(m2p[3])) <<< 1;
      qc2 <= WABC'(m2p[4]) - WABC'(m2p[5]);
      h42 <= m2p[6];
    end
  end

  // ---------------------------------------------------------------- round 3
  logic signed [WP3-1:0] bb3p, ac3p;

  crc_mul #(.WA(WABC), .WB(WABC), .LB(LB3)) u_mul_bb (
    .clk (clk),
    .en  (adv),
    .a   (qb2),
    .b   (qb2),
    .p   (bb3p)
  );

  crc_mul #(.WA(WABC), .WB(WABC), .LB(LB3)) u_mul_ac (
    .clk (clk),
    .en  (adv),
    .a   (qa2),
    .b   (qc2),
    .p   (ac3p)
  );

  logic [2*WABC+WP2-1:0] side3;

  crc_delay #(.W(2*WABC+WP2), .D(L3)) u_dly_m3 (
    .clk (clk),
    .en  (adv),
    .d   ({qa2, qb2, h42}),
    .q   (side3)
  );

  logic signed [WP3+2:0]  dfull;
  logic signed [WD-1:0]   d3;
  logic signed [WABC-1:0] a3, b3;
  logic signed [WP2-1:0]  h43;

  assign dfull = (WP3+3)'(bb3p) - ((WP3+3)'(ac3p) <<< 2);

  always_ff @(posedge clk) begin
    if (adv) begin
      d3  <= dfull[WD-1:0];
      a3  <= side3[2*WABC+WP2-1 -: WABC];
      b3  <= side3[WABC+WP2-1 -: WABC];
      h43 <= side3[WP2-1:0];
    end
  end

  // ---------------------------------------------------------------- threshold
  logic signed [W1K-1:0]  d1k4;
  logic signed [WD-1:0]   d4;
  logic signed [WABC-1:0] a4, b4;
  logic signed [WP2-1:0]  h44;

  always_ff @(posedge clk) begin
    if (adv) begin
      d1k4 <= (W1K'(d3) <<< 10) - (W1K'(d3) <<< 4) - (W1K'(d3) <<< 3);
      d4   <= d3;
      a4   <= a3;
      b4   <= b3;
      h44  <= h43;
    end
  end

  logic                   ok5, aneg5;
  logic [WD-1:0]          dm5;
  logic signed [WABC-1:0] b5;
  logic [WABC-1:0]        absa5;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok5   <= (a4 != '0) && !d4[WD-1] && (WCMP'(d1k4) >= (WCMP'(h44) <<< (4 * F)));
      dm5   <= d4[WD-1] ? '0 : d4;
      aneg5 <= a4[WABC-1];
      absa5 <= a4[WABC-1] ? WABC'(-a4) : WABC'(a4);
      b5    <= b4;
    end
  end

  // ---------------------------------------------------------------- sqrt
  logic [WSQ-1:0] sq_rem [LSQ];
  logic [WR-1:0]  sq_q   [LSQ];
  logic [WD-1:0]  sq_d   [LSQ];

  // one root bit per stage, two radicand bits shifted in
  for (genvar k = 0; k < LSQ; k++) begin : g_sq
    logic [WSQ-1:0] rem_in, r, trial;
    logic [WR-1:0]  q_in;
    logic [WD-1:0]  d_in;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign d_in   = dm5;
    end else begin : g_next
      assign rem_in = sq_rem[k-1];
      assign q_in   = sq_q[k-1];
      assign d_in   = sq_d[k-1];
    end

    assign r     = {rem_in[WSQ-3:0], d_in[WD-1 -: 2]};
    assign trial = WSQ'({q_in, 2'b01});
    assign ge    = r >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[k] <= ge ? r - trial : r;
        sq_q[k]   <= {q_in[WR-2:0], ge};
        sq_d[k]   <= d_in << 2;
      end
    end
  end

  logic [2*WABC+1:0] side_sq;

  crc_delay #(.W(2*WABC+2), .D(LSQ)) u_dly_sq (
    .clk (clk),
    .en  (adv),
    .d   ({ok5, aneg5, b5, absa5}),
    .q   (side_sq)
  );

  // ---------------------------------------------------------------- numerator
  logic                  sq_ok, sq_aneg;
  logic signed [WABC-1:0] sq_b;
  logic [WABC-1:0]       sq_absa;
  logic signed [WNS-1:0] nsel, nval, nabs;

  assign sq_ok   = side_sq[2*WABC+1];
  assign sq_aneg = side_sq[2*WABC];
  assign sq_b    = side_sq[2*WABC-1 -: WABC];
  assign sq_absa = side_sq[WABC-1:0];
  assign nsel    = sq_aneg ? WNS'(sq_b) : -WNS'(sq_b);
  assign nval    = nsel - WNS'($signed({1'b0, sq_q[LSQ-1]}));
  assign nabs    = nval[WNS-1] ? -nval : nval;

  logic          ok6, neg6;
  logic [WV-1:0] mag6, den6;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok6  <= sq_ok;
      neg6 <= nval[WNS-1];
      mag6 <= WV'($unsigned(nabs)) << F;
      den6 <= WV'({sq_absa, 1'b0});
    end
  end

  logic          okf7, neg7;
  logic [WV-1:0] mag7, den7;

  // quotient at or above 2^QB cannot fit: drop it here
  always_ff @(posedge clk) begin
    if (adv) begin
      okf7 <= ok6 && (mag6 < (den6 << QB));
      neg7 <= neg6;
      mag7 <= mag6;
      den7 <= den6;
    end
  end

  // ---------------------------------------------------------------- divider
  logic [WV-1:0] dv_rem [LDV];
  logic [WV-1:0] dv_den [LDV];
  logic [QB-1:0] dv_q   [LDV];

  for (genvar k = 0; k < LDV; k++) begin : g_dv
    logic [WV-1:0] rem_in, den_in, dsh;
    logic [QB-1:0] q_in;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = mag7;
      assign den_in = den7;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = dv_rem[k-1];
      assign den_in = dv_den[k-1];
      assign q_in   = dv_q[k-1];
    end

    assign dsh = den_in << (QB - 1 - k);
    assign ge  = rem_in >= dsh;

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[k] <= ge ? rem_in - dsh : rem_in;
        dv_den[k] <= den_in;
        dv_q[k]   <= {q_in[QB-2:0], ge};
      end
    end
  end

  logic [1:0] side_dv;

  crc_delay #(.W(2), .D(LDV)) u_dly_dv (
    .clk (clk),
    .en  (adv),
    .d   ({neg7, okf7}),
    .q   (side_dv)
  );

  // ---------------------------------------------------------------- round down
  logic          dv_neg, dv_okf, rnz;
  logic [QB:0]   qadj;

  assign dv_neg = side_dv[1];
  assign dv_okf = side_dv[0];
  assign rnz    = dv_rem[LDV-1] != '0;
  assign qadj   = {1'b0, dv_q[LDV-1]} + (QB+1)'(dv_neg && rnz);

  logic                 fits8;
  logic signed [CW-1:0] t8;

  always_ff @(posedge clk) begin
    if (adv) begin
      fits8 <= dv_okf && (dv_neg ? (qadj <= QMAX_NEG) : (qadj <= QMAX_POS));
      t8    <= dv_neg ? -$signed(qadj[CW-1:0]) : $signed(qadj[CW-1:0]);
    end
  end

  // ---------------------------------------------------------------- height test
  logic [2*CW-1:0]      side_oy;
  logic signed [CW-1:0] oyd, dyd;

  crc_delay #(.W(2*CW), .D(P8)) u_dly_oy (
    .clk (clk),
    .en  (adv),
    .d   ({oy0, dy0}),
    .q   (side_oy)
  );

  assign oyd = $signed(side_oy[2*CW-1:CW]);
  assign dyd = $signed(side_oy[CW-1:0]);

  logic                   ok9;
  logic signed [CW-1:0]   t9, oy9;
  logic signed [2*CW-1:0] prod9;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok9   <= fits8;
      t9    <= t8;
      oy9   <= oyd;
      prod9 <= (2*CW)'(t8) * (2*CW)'(dyd);
    end
  end

  logic signed [2*CW+1:0] yv, lo, hi;
  logic                   hit_c;

  assign yv    = ((2*CW+2)'(oy9) <<< F) + (2*CW+2)'(prod9);
  assign lo    = (2*CW+2)'(centre_y) <<< F;
  assign hi    = ((2*CW+2)'(centre_y) + (2*CW+2)'($signed({1'b0, cone_height}))) <<< F;
  assign hit_c = ok9 && (yv > lo) && (yv < hi);

  logic          hit10;
  logic [CW-1:0] dist10;

  always_ff @(posedge clk) begin
    if (adv) begin
      hit10  <= hit_c;
      dist10 <= hit_c ? t9 : MISS;
    end
  end

  assign m_tdata = {7'b0, dist10, hit10};

  // ---------------------------------------------------------------- checks
  a_sqrt_floor: assert property (@(posedge clk) disable iff (rst)
    v[PSQ] |-> (sq_rem[LSQ-1] <= (WSQ'(sq_q[LSQ-1]) << 1)))
    else $error("square root remainder exceeds 2*root");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (v[PDV] && dv_okf) |-> (dv_rem[LDV-1] < dv_den[LDV-1]))
    else $error("divider remainder not below divisor");

  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[32:1] == MISS))
    else $error("miss word without the miss distance");

endmodule

>>> sim/cone_ray_checker.sv
module cone_ray_checker #(
  parameter int FRAC_BITS = crc_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [191:0]             s_tdata,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [39:0]              m_tdata,
  input  logic                     cfg_we,
  input  logic [crc_pkg::IDXW-1:0] cfg_index,
  input  logic [31:0]              cfg_data,
  output int                       errors,
  output int                       pending
);

  typedef logic signed [319:0] wide_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] distance;
  } hit_t;

  longint cone_cx, cone_cy, cone_cz, cone_r, cone_h;
  hit_t   hits_due[$];

  function automatic wide_t isqrt(wide_t d);
    wide_t r, c;
    r = '0;
    for (int i = 135; i >= 0; i--) begin
      c = r | (wide_t'(1) <<< i);
      if (c * c <= d) r = c;
    end
    return r;
  endfunction

  function automatic hit_t trace_ray(logic [191:0] w);
    longint ox, oy, oz, dx, dy, dz, an, bn, dn, sc, t, lo, hi, yv;
    wide_t  h2, r2, qa, qb, qc, disc, thr, num, den, mag, q, s, wdx, wdy, wdz;
    logic   neg, rnz, fits;
    hit_t   res;
    ox = longint'($signed(w[31:0]));
    oy = longint'($signed(w[63:32]));
    oz = longint'($signed(w[95:64]));
    dx = longint'($signed(w[127:96]));
    dy = longint'($signed(w[159:128]));
    dz = longint'($signed(w[191:160]));
    sc = longint'(1) <<< FRAC_BITS;
    an = ox - cone_cx;
    bn = oz - cone_cz;
    dn = cone_h - oy + cone_cy;
    h2 = wide_t'(cone_h) * wide_t'(cone_h);
    r2 = wide_t'(cone_r) * wide_t'(cone_r);
    wdx = wide_t'(dx);
    wdy = wide_t'(dy);
    wdz = wide_t'(dz);
    qa = h2 * (wdx * wdx + wdz * wdz) - r2 * wdy * wdy;
    qb = 2 * (h2 * (wide_t'(an) * wdx + wide_t'(bn) * wdz) + r2 * wide_t'(dn) * wdy);
    qc = h2 * (wide_t'(an) * wide_t'(an) + wide_t'(bn) * wide_t'(bn))
       - r2 * wide_t'(dn) * wide_t'(dn);
    disc = qb * qb - 4 * qa * qc;
    thr = h2 * h2 * (wide_t'(sc) ** 4);
    res.hit = 1'b0;
    res.distance = 32'(-sc);
    if (qa != 0 && disc >= 0 && 1000 * disc >= thr) begin
      s = isqrt(disc);
      num = ((qa < 0) ? qb : -qb) - s;
      num = num * wide_t'(sc);
      den = 2 * ((qa < 0) ? -qa : qa);
      neg = num < 0;
      mag = neg ? -num : num;
      q = mag / den;
      rnz = (mag % den) != 0;
      if (neg && rnz) q = q + 1;
      fits = neg ? (q <= (wide_t'(1) <<< 31)) : (q < (wide_t'(1) <<< 31));
      if (fits) begin
        t = neg ? -longint'(q) : longint'(q);
        lo = cone_cy * sc;
        hi = (cone_cy + cone_h) * sc;
        yv = oy * sc + t * dy;
        if (yv > lo && yv < hi) begin
          res.hit = 1'b1;
          res.distance = 32'(t);
        end
      end
    end
    return res;
  endfunction

  assign pending = hits_due.size();

  always @(posedge clk) begin
    hit_t want;
    if (rst) begin
      cone_cx = 0;
      cone_cy = 0;
      cone_cz = 0;
      cone_r  = longint'(crc_pkg::RADIUS_RST);
      cone_h  = longint'(crc_pkg::HEIGHT_RST);
      errors  = 0;
      hits_due.delete();
    end else begin
      if (cfg_we) begin
        case (crc_pkg::reg_idx_t'(cfg_index))
          crc_pkg::REG_CENTRE_X:    cone_cx = longint'($signed(cfg_data));
          crc_pkg::REG_CENTRE_Y:    cone_cy = longint'($signed(cfg_data));
          crc_pkg::REG_CENTRE_Z:    cone_cz = longint'($signed(cfg_data));
          crc_pkg::REG_CONE_RADIUS: cone_r  = longint'(cfg_data[30:0]);
          crc_pkg::REG_CONE_HEIGHT: cone_h  = longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) hits_due = {hits_due, trace_ray(s_tdata)};
      if (m_tvalid && m_tready) begin
        if (hits_due.size() == 0) begin
          $display("%0t: unexpected result word hit=%0b distance=%h",
                   $time, m_tdata[0], m_tdata[32:1]);
          errors++;
        end else begin
          want = hits_due.pop_front();
          if (m_tdata[0] !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_tdata[0]);
            errors++;
          end
          if (m_tdata[32:1] !== want.distance) begin
            $display("%0t: distance expected %h actual %h",
                     $time, want.distance, m_tdata[32:1]);
            errors++;
          end
        end
      end
    end
  end
endmodule

>>> sim/tb_cone_ray_intersection.sv
module tb_cone_ray_intersection;

  localparam int  DRAIN_CYCLES = 250;
  localparam int  STALL_LIMIT  = 20000;
  localparam int  PHASE_RAYS   = 220;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [191:0]             s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [39:0]              m_tdata;
  logic                     cfg_we = 1'b0;
  logic [crc_pkg::IDXW-1:0] cfg_index = crc_pkg::REG_CENTRE_X;
  logic [31:0]              cfg_data = '0;
  int                       errors, pending;
  int                       send_idle = 26, recv_idle = 65;
  int                       quiet_cycles = 0;
  longint                   cx, cy, cz, rad, hgt;

  always #10 clk = ~clk;

  cone_ray_intersection i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  cone_ray_checker i_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending
  );

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random backpressure, plus one long hold-off to fill the pipeline
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 1500) begin
        for (int i = 0; i < 600; i++) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // hold the word until accepted; the next call or the caller drops tvalid
  task automatic send_word(logic [191:0] w);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_ray(longint ox, oy, oz, dx, dy, dz);
    send_word({32'(dz), 32'(dy), 32'(dx), 32'(oz), 32'(oy), 32'(ox)});
  endtask

  task automatic write_reg(crc_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_cone(longint x, y, z, r, h);
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cx = x; cy = y; cz = z; rad = r; hgt = h;
    write_reg(crc_pkg::REG_CENTRE_X, 32'(x));
    write_reg(crc_pkg::REG_CENTRE_Y, 32'(y));
    write_reg(crc_pkg::REG_CENTRE_Z, 32'(z));
    write_reg(crc_pkg::REG_CONE_RADIUS, 32'(r));
    write_reg(crc_pkg::REG_CONE_HEIGHT, 32'(h));
    cfg_we <= 1'b0;
  endtask

  function automatic longint spread(longint span);
    return longint'($urandom_range(32'(2 * span))) - span;
  endfunction

  // one word in four is random; the rest aim at a point near the axis inside the height band, from around the cone
  task automatic random_rays(int count);
    longint ox, oy, oz, tx, ty, tz, span;
    int     sh;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0) begin
        send_word({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
      end else begin
        span = (hgt > rad ? hgt : rad);
        if (span > 64'd200000000) span = 64'd200000000;
        ox = cx + spread(3 * span);
        oy = cy + spread(2 * span);
        oz = cz + spread(3 * span);
        tx = cx + spread(rad > span ? span : rad);
        ty = cy + longint'($urandom_range(32'(hgt > span ? span : hgt)));
        tz = cz + spread(rad > span ? span : rad);
        sh = $urandom_range(2);
        send_ray(ox, oy, oz, (tx - ox) >>> sh, (ty - oy) >>> sh, (tz - oz) >>> sh);
      end
    end
  endtask

  initial begin
    cx = 0; cy = 0; cz = 0; rad = 65536; hgt = 65536;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset cone: radius 1.0, height 1.0
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_word({6{32'h80000000}});
    send_ray(-131072, 32768, 0, 65536, 0, 0);
    send_ray(131072, 16384, 0, -65536, 0, 0);
    send_ray(6554, 131072, 0, 0, -65536, 0);
    send_ray(0, 131072, 0, 0, -65536, 0);
    send_ray(-131072, 98304, 0, 65536, 0, 0);
    send_ray(-131072, 32768, 32768, 65536, 0, 0);
    send_ray(-131072, 0, 65536, 65536, 0, 0);
    send_ray(-131072, 32768, 0, 65536, 1, 0);
    send_ray(-131072, -32768, 0, 65536, 65536, 0);
    send_ray(-65536, 0, -65536, 65536, 65536, 65536);
    send_ray(0, -65536, 0, 0, 65536, 0);
    send_ray(-1, 65535, 0, 1, 0, 0);
    random_rays(PHASE_RAYS);

    set_cone(longint'($urandom_range(65536)) - 32768, 40000, -20000,
             $urandom_range(1 << 20, 1 << 14), $urandom_range(1 << 20, 1 << 14));
    random_rays(PHASE_RAYS);

    set_cone(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 1, 64'h7fffffff);
    random_rays(PHASE_RAYS / 2);

    send_idle = 65;
    recv_idle = 26;
    set_cone(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 64'h7fffffff, 1);
    random_rays(PHASE_RAYS / 2);

    set_cone(0, -100000, 0, 64'h7fffffff, 64'h7fffffff);
    random_rays(PHASE_RAYS / 2);

    set_cone(spread(1 << 20), spread(1 << 20), spread(1 << 20),
             $urandom_range(1 << 18, 1 << 12), $urandom_range(1 << 18, 1 << 12));
    random_rays(PHASE_RAYS);

    send_idle = 0;
    recv_idle = 0;
    set_cone(spread(1 << 16), spread(1 << 16), spread(1 << 16),
             $urandom_range(1 << 17, 256), $urandom_range(1 << 17, 256));
    random_rays(PHASE_RAYS);

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> cone_ray_intersection.f
hw/rtl/crc_pkg.sv
hw/rtl/crc_delay.sv
hw/rtl/crc_mul.sv
hw/rtl/cone_ray_intersection.sv
sim/cone_ray_checker.sv
sim/tb_cone_ray_intersection.sv
